@@ src/psfc_pkg.sv @@
// ----------------------------------------------------------------------------
// psfc_pkg: shared types and constants for the packed sample frame checker
// Holds the request and result records, the byte position code, the field
// masks and the byte-wide CRC-8 step (polynomial x^8+x^2+x+1, MSB first).
// ----------------------------------------------------------------------------
`default_nettype none

package psfc_pkg;

    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 12;
    localparam int CHANNEL_W = 6;

    localparam logic [BYTE_W-1:0]    CRC_POLY     = 8'h07;
    localparam logic [BYTE_W-1:0]    CRC_TOP_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0]    LOW_NIBBLE   = 8'h0F;
    localparam logic [BYTE_W-1:0]    HIGH_NIBBLE  = 8'hF0;
    localparam logic [CHANNEL_W-1:0] CHANNEL_MAX  = 6'd63;

    // Result kinds carried on the master tuser bit
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Position of the next data byte inside its three-byte group
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    // One received request held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              last_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic                 result_kind;
        logic [SAMPLE_W-1:0]  sample_value;
        logic [CHANNEL_W-1:0] channel_number;
        logic                 check_ok;
    } result_t;

    // Advance the CRC over one whole byte, most significant bit first
    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] r;
        r = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((r & CRC_TOP_BIT) != '0) begin
                r = {r[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[BYTE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/psfc_in_reg.sv @@
// ----------------------------------------------------------------------------
// psfc_in_reg: input register
// Captures one request from the slave channel and holds it until the frame
// logic passes it on to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psfc_in_reg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [psfc_pkg::BYTE_W-1:0] s_byte,
    input  wire logic                      s_last,
    input  wire logic                      advance,
    output psfc_pkg::item_t                item
);

    logic                        valid_reg,  valid_next;
    logic [psfc_pkg::BYTE_W-1:0] byte_reg,   byte_next;
    logic                        last_reg,   last_next;
    logic                        take;

    // Accept a new request whenever the held one is empty or moving on
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    // Next contents of the input register
    always_comb begin
        valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);
        byte_next  = take ? s_byte : byte_reg;
        last_next  = take ? s_last : last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign item.valid     = valid_reg;
    assign item.rx_byte   = byte_reg;
    assign item.last_byte = last_reg;

endmodule

`default_nettype wire

@@ src/psfc_frame_core.sv @@
// ----------------------------------------------------------------------------
// psfc_frame_core: frame state, CRC and sample unpacking
// Updates the running CRC, the group position and the channel count for the
// request leaving the input register, and forms its result item.
// ----------------------------------------------------------------------------
`default_nettype none

module psfc_frame_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [psfc_pkg::BYTE_W-1:0] cfg_wr_data,
    input  wire psfc_pkg::item_t             item,
    input  wire logic                        advance,
    output logic                             has_result,
    output psfc_pkg::result_t                result
);

    logic [psfc_pkg::BYTE_W-1:0]    seed_reg,     seed_next;
    logic [psfc_pkg::BYTE_W-1:0]    crc_reg,      crc_next;
    logic [psfc_pkg::BYTE_W-1:0]    prev_reg,     prev_next;
    logic [psfc_pkg::CHANNEL_W-1:0] count_reg,    count_next;
    logic                           in_frame_reg, in_frame_next;
    psfc_pkg::phase_t               phase_reg,    phase_next;

    logic                           step;
    logic                           data_step;
    logic                           check_step;
    logic [psfc_pkg::CHANNEL_W-1:0] count_inc;
    logic [psfc_pkg::BYTE_W-1:0]    b;
    logic [3:0]                     b_low;
    logic [3:0]                     prev_high;
    logic [psfc_pkg::SAMPLE_W-1:0]  sample;
    logic                           sample_out;

    assign b          = item.rx_byte;
    assign step       = item.valid && advance;
    assign data_step  = step && !item.last_byte;
    assign check_step = step && item.last_byte;

    // Saturate the channel count at its top value
    assign count_inc = (count_reg == psfc_pkg::CHANNEL_MAX) ?
                       count_reg : count_reg + 1'b1;

    assign b_low     = 4'(b & psfc_pkg::LOW_NIBBLE);
    assign prev_high = 4'((prev_reg & psfc_pkg::HIGH_NIBBLE) >> 4);

    // Next group position
    always_comb begin
        unique case (phase_reg)
            psfc_pkg::PHASE_FIRST:  phase_next = psfc_pkg::PHASE_SECOND;
            psfc_pkg::PHASE_SECOND: phase_next = psfc_pkg::PHASE_THIRD;
            psfc_pkg::PHASE_THIRD:  phase_next = psfc_pkg::PHASE_FIRST;
            default:                phase_next = psfc_pkg::PHASE_SECOND;
        endcase
    end

    // Assemble the sample completed by this byte, if any
    always_comb begin
        unique case (phase_reg)
            psfc_pkg::PHASE_SECOND: begin
                sample     = {b_low, prev_reg};
                sample_out = 1'b1;
            end
            psfc_pkg::PHASE_THIRD: begin
                sample     = {b, prev_high};
                sample_out = 1'b1;
            end
            default: begin
                sample     = '0;
                sample_out = 1'b0;
            end
        endcase
    end

    // Form the result item
    always_comb begin
        has_result = item.last_byte || sample_out;
        if (item.last_byte) begin
            result.result_kind    = psfc_pkg::KIND_VERDICT;
            result.sample_value   = '0;
            result.channel_number = '0;
            result.check_ok       = (b == crc_reg);
        end else begin
            result.result_kind    = psfc_pkg::KIND_SAMPLE;
            result.sample_value   = sample;
            result.channel_number = count_inc;
            result.check_ok       = 1'b0;
        end
    end

    // Next frame state: seed writes, data bytes and the closing check byte
    always_comb begin
        seed_next     = cfg_wr_en ? cfg_wr_data : seed_reg;
        crc_next      = crc_reg;
        prev_next     = prev_reg;
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        if (cfg_wr_en && !in_frame_reg) begin
            crc_next = cfg_wr_data;
        end
        priority if (check_step) begin
            crc_next      = seed_next;
            prev_next     = '0;
            count_next    = '0;
            in_frame_next = 1'b0;
        end else if (data_step) begin
            crc_next      = psfc_pkg::crc8_step(crc_reg, b);
            prev_next     = b;
            count_next    = sample_out ? count_inc : count_reg;
            in_frame_next = 1'b1;
        end else begin
            in_frame_next = in_frame_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg     <= '0;
            crc_reg      <= '0;
            prev_reg     <= '0;
            count_reg    <= '0;
            in_frame_reg <= 1'b0;
            phase_reg    <= psfc_pkg::PHASE_FIRST;
        end else begin
            seed_reg     <= seed_next;
            crc_reg      <= crc_next;
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
            if (check_step) begin
                phase_reg <= psfc_pkg::PHASE_FIRST;
            end else if (data_step) begin
                phase_reg <= phase_next;
            end
        end
    end

    // A check byte leaves the frame state cleared
    a_clear_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        check_step |=> (phase_reg == psfc_pkg::PHASE_FIRST) && (count_reg == '0)
                       && !in_frame_reg)
        else $error("frame state not cleared after check byte");

    // A data byte always opens or continues a frame
    a_frame_open: assert property (@(posedge aclk) disable iff (!aresetn)
        data_step |=> in_frame_reg)
        else $error("data byte did not mark frame open");

    // A partly filled group only exists inside a frame
    a_phase_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != psfc_pkg::PHASE_FIRST) |-> in_frame_reg)
        else $error("group position set outside a frame");

endmodule

`default_nettype wire

@@ src/psfc_out_reg.sv @@
// ----------------------------------------------------------------------------
// psfc_out_reg: result register
// Holds one result item for the master channel while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module psfc_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic              load_valid,
    input  wire psfc_pkg::result_t result,
    output logic                   out_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output psfc_pkg::result_t      m_result
);

    logic              valid_reg, valid_next;
    psfc_pkg::result_t data_reg,  data_next;

    // Free when empty or when the held result is taken this cycle
    assign out_ready = !valid_reg || m_tready;

    // Load the new result or drop the delivered one
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (out_ready) begin
            valid_next = load && load_valid;
            data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire

@@ src/packed_sample_frame_checker.sv @@
// ----------------------------------------------------------------------------
// packed_sample_frame_checker: CRC-8 frame check with 12-bit sample unpack
// Top level: input register, frame logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one reply byte per request in s_tdata[7:0];
//   s_tlast marks the check byte that closes the frame. Data bytes feed a
//   CRC-8 (poly 0x07, MSB first) and are unpacked three bytes to two 12-bit
//   samples. Each finished sample leaves on the master channel with its
//   channel number (saturating at 63); the check byte yields a pass/fail
//   verdict, and m_tuser tells the two kinds apart. A byte in the first
//   position of its group yields nothing.
//   The input register takes each accepted byte, and the result register
//   then takes any result it yields when free, which raises m_tvalid.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the combinational byte-wide CRC step between the two registers.
//   Reset (aresetn low, synchronous) empties both registers, zeroes the
//   seed and clears the frame state. When the receiver stalls, the result is
//   held and s_tready stays high until the input register is also occupied.
//   cfg_wr_en/cfg_wr_data set the CRC seed, applied at once between frames
//   and from the next frame otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_sample_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Seed register write
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // Slave channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // last_byte
    // Master channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [11:0] sample_value, [17:12] channel_number,
                                        // [18] check_ok, [23:19] zero
    output logic [0:0]       m_tuser    // [0] result_kind
);

    psfc_pkg::item_t   item;
    psfc_pkg::result_t result;
    psfc_pkg::result_t m_result;
    logic              advance;
    logic              out_ready;
    logic              has_result;

    // Move the held request on when the result register can take it
    assign advance = item.valid && out_ready;

    psfc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_last   (s_tlast),
        .advance  (advance),
        .item     (item)
    );

    psfc_frame_core u_frame_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .advance     (advance),
        .has_result  (has_result),
        .result      (result)
    );

    psfc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_valid (has_result),
        .result     (result),
        .out_ready  (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

    // Pack the result onto the master channel
    assign m_tdata = {5'd0, m_result.check_ok, m_result.channel_number,
                      m_result.sample_value};
    assign m_tuser = m_result.result_kind;

    // A verdict carries no sample and no channel number
    a_verdict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == psfc_pkg::KIND_VERDICT)) |-> (m_tdata[17:0] == '0))
        else $error("verdict carries sample fields");

    // A sample has a channel number and never a pass flag
    a_sample_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == psfc_pkg::KIND_SAMPLE)) |->
            ((m_tdata[17:12] != '0) && !m_tdata[18]))
        else $error("sample fields malformed");

endmodule

`default_nettype wire
